### hw/rtl/lsb1_stego_extractor_core_defines.svh
// assertion helpers for the lsb1 extractor core
`ifndef LSB1_STEGO_EXTRACTOR_CORE_DEFINES_SVH
`define LSB1_STEGO_EXTRACTOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LSB1_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsb1 extractor check failed");

// next-cycle implication, sampled on clk, off during reset
`define LSB1_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsb1 extractor check failed");

`endif

### hw/rtl/lsb1_pkg.sv
package lsb1_pkg;

    localparam logic [7:0]  DOT_CHAR     = 8'h2E;
    localparam logic [31:0] HEADER_BYTES = 32'd4;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_ENCRYPTED_MODE = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_RUN       = 2'd0,
        ST_DONE      = 2'd1,
        ST_CAPACITY  = 2'd2,
        ST_TOO_LARGE = 2'd3
    } status_t;

    typedef struct packed {
        logic        encrypted;
        logic [30:0] capacity;
    } cfg_t;

    typedef struct packed {
        logic       start_of_image;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [31:0] payload_size;
        logic [31:0] byte_number;
        logic [7:0]  data_byte;
        status_t     status;
    } result_t;

endpackage

### hw/rtl/lsb1_cfg_regs.sv
module lsb1_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [1:0]     cfg_index,
    input  logic [15:0]    cfg_data,
    output lsb1_pkg::cfg_t cfg
);
    import lsb1_pkg::*;

    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic        enc_reg, enc_next;
    logic [30:0] cap_reg, cap_next;
    logic [31:0] area;
    logic [33:0] area_x3;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        enc_next    = enc_reg;
        if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_IMAGE_WIDTH:    width_next  = cfg_data;
                CFG_IMAGE_HEIGHT:   height_next = cfg_data;
                CFG_ENCRYPTED_MODE: enc_next    = cfg_data[0];
                default:            ;
            endcase
        end
        // capacity in bytes follows the new size at the same edge
        area     = 32'(width_next) * 32'(height_next);
        area_x3  = {2'b00, area} + {1'b0, area, 1'b0};
        cap_next = area_x3[33:3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
            enc_reg    <= 1'b0;
            cap_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            enc_reg    <= enc_next;
            cap_reg    <= cap_next;
        end
    end

    assign cfg.encrypted = enc_reg;
    assign cfg.capacity  = cap_reg;

endmodule

### hw/rtl/lsb1_byte_asm.sv
module lsb1_byte_asm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  lsb1_pkg::pixel_t  pixel,
    input  lsb1_pkg::cfg_t    cfg,
    output logic              byte_valid,
    output lsb1_pkg::result_t result
);
    import lsb1_pkg::*;

    logic [7:0]  shift_reg, shift_next;
    logic [2:0]  bits_reg, bits_next;
    logic [31:0] bytes_reg, bytes_next;
    logic [31:0] size_reg, size_next;
    logic        dot_reg, dot_next;
    logic        fin_reg, fin_next;

    logic [7:0]  cur_shift;
    logic [2:0]  cur_bits;
    logic [31:0] cur_bytes;
    logic [31:0] cur_size;
    logic        cur_dot;
    logic        cur_fin;
    logic [2:0]  lsb;
    logic        complete;
    logic [7:0]  new_byte;
    logic [7:0]  rem_shift;
    logic [2:0]  rem_bits;
    logic [31:0] inc;
    logic [31:0] size_new;
    logic [32:0] size_plus4;
    logic        too_large;
    logic        payload_end;
    logic        at_capacity;
    logic        dot_set;
    status_t     status;

    always_comb
    begin
        cur_shift = pixel.start_of_image ? 8'd0  : shift_reg;
        cur_bits  = pixel.start_of_image ? 3'd0  : bits_reg;
        cur_bytes = pixel.start_of_image ? 32'd0 : bytes_reg;
        cur_size  = pixel.start_of_image ? 32'd0 : size_reg;
        cur_dot   = pixel.start_of_image ? 1'b0  : dot_reg;
        cur_fin   = pixel.start_of_image ? 1'b0  : fin_reg;
        lsb       = {pixel.blue[0], pixel.green[0], pixel.red[0]};

        complete  = 1'b0;
        new_byte  = '0;
        rem_shift = '0;
        rem_bits  = '0;
        // a pixel brings three bits, so at most one byte closes
        case (cur_bits)
            3'd5:
            begin
                complete = 1'b1;
                new_byte = {cur_shift[4:0], lsb};
            end
            3'd6:
            begin
                complete  = 1'b1;
                new_byte  = {cur_shift[5:0], lsb[2:1]};
                rem_shift = {7'd0, lsb[0]};
                rem_bits  = 3'd1;
            end
            3'd7:
            begin
                complete  = 1'b1;
                new_byte  = {cur_shift[6:0], lsb[2]};
                rem_shift = {6'd0, lsb[1:0]};
                rem_bits  = 3'd2;
            end
            default:
            begin
                rem_shift = {cur_shift[4:0], lsb};
                rem_bits  = cur_bits + 3'd3;
            end
        endcase

        inc        = cur_bytes + 32'd1;
        size_new   = (cur_bytes < HEADER_BYTES) ? {cur_size[23:0], new_byte} : cur_size;
        size_plus4 = {1'b0, size_new} + {1'b0, HEADER_BYTES};
        too_large  = (inc == HEADER_BYTES) && (size_plus4 > {2'b00, cfg.capacity});
        // payload checks only once the whole header is in
        payload_end = (inc >= HEADER_BYTES) && ({1'b0, inc} >= size_plus4);
        at_capacity = {1'b0, inc} >= {2'b00, cfg.capacity};

        status  = ST_RUN;
        dot_set = 1'b0;
        if (too_large)
        begin
            status = ST_TOO_LARGE;
        end
        else
        begin
            if (payload_end)
            begin
                if (cfg.encrypted)
                    status = ST_DONE;
                else if (!cur_dot && new_byte == DOT_CHAR)
                    dot_set = 1'b1;
                else if (cur_dot && new_byte == 8'd0)
                    status = ST_DONE;
            end
            if (status == ST_RUN && at_capacity)
                status = ST_CAPACITY;
        end

        byte_valid = !cur_fin && complete;

        shift_next = cur_shift;
        bits_next  = cur_bits;
        bytes_next = cur_bytes;
        size_next  = cur_size;
        dot_next   = cur_dot;
        fin_next   = cur_fin;
        if (!cur_fin)
        begin
            shift_next = rem_shift;
            bits_next  = rem_bits;
            if (complete)
            begin
                bytes_next = inc;
                size_next  = size_new;
                dot_next   = cur_dot || dot_set;
                fin_next   = (status != ST_RUN);
            end
        end

        result.data_byte    = new_byte;
        result.byte_number  = cur_bytes;
        result.payload_size = size_new;
        result.status       = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            bits_reg  <= '0;
            bytes_reg <= '0;
            size_reg  <= '0;
            dot_reg   <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else if (step)
        begin
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
            bytes_reg <= bytes_next;
            size_reg  <= size_next;
            dot_reg   <= dot_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

### hw/rtl/lsb1_stego_extractor_core.sv
// LSB1 extractor: one pixel per transaction on the slave side, at a sustained rate
// of one pixel per clock while m_tready does not hold the output. The low bits of
// blue, green and red are shifted in, MSB first; each pixel that closes a byte
// yields one result transaction, registered through the input register, then the
// byte assembler into the output register, so the rate is set by the byte
// assembler and its extraction state. Results carry the byte, its position, the
// 32-bit size header and a status; tlast marks the end of an extraction, after
// which pixels are dropped until one arrives with tuser set. Byte capacity
// (width*height*3/8) is registered together with the configuration write.
`include "lsb1_stego_extractor_core_defines.svh"

module lsb1_stego_extractor_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // blue[7:0], green[15:8], red[23:16]
    input  logic        s_tuser,   // start_of_image
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // data_byte[7:0], byte_number[39:8], payload_size[71:40]
    output logic [1:0]  m_tuser,   // status
    output logic        m_tlast
);
    import lsb1_pkg::*;

    cfg_t    cfg;
    pixel_t  pix_reg;
    logic    in_valid_reg;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg;
    logic    byte_valid;
    logic    advance;
    logic    step;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    lsb1_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsb1_byte_asm u_asm (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .pixel      (pix_reg),
        .cfg        (cfg),
        .byte_valid (byte_valid),
        .result     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= step && byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            pix_reg.start_of_image <= s_tuser;
            pix_reg.blue           <= s_tdata[7:0];
            pix_reg.green          <= s_tdata[15:8];
            pix_reg.red            <= s_tdata[23:16];
        end
        if (step && byte_valid && advance)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.payload_size, out_reg.byte_number, out_reg.data_byte};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = (out_reg.status != ST_RUN);

    `LSB1_ASSERT_IMP(a_too_large_at_header, m_tvalid && m_tuser == ST_TOO_LARGE, m_tdata[39:8] == 32'd3)
    `LSB1_ASSERT_IMP(a_ready_when_empty, !in_valid_reg, s_tready)
    `LSB1_ASSERT_NXT(a_held_pixel_kept, in_valid_reg && !advance, in_valid_reg)
    `LSB1_ASSERT_IMP(a_header_size_known, m_tvalid && m_tlast && m_tuser != ST_CAPACITY, m_tdata[39:8] >= 32'd3)

endmodule

### bench/lsb1_checker.sv
`timescale 1ns / 100ps

module lsb1_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // blue[7:0], green[15:8], red[23:16]
    input  logic        s_tuser,   // start_of_image
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // data_byte[7:0], byte_number[39:8], payload_size[71:40]
    input  logic [1:0]  m_tuser,   // status
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    import lsb1_pkg::*;

    typedef struct {
        logic [7:0]  data;
        logic [31:0] number;
        logic [31:0] size;
        status_t     status;
    } hidden_byte_t;

    hidden_byte_t expected_bytes[$];

    logic [15:0] img_w;
    logic [15:0] img_h;
    logic        enc_mode;

    logic [7:0]  shift_reg;
    int          nbits;
    logic [31:0] bytes_taken;
    logic [31:0] size_hdr;
    logic        dot_found;
    logic        extraction_over;

    function automatic void clear_extraction();
        shift_reg       = '0;
        nbits           = 0;
        bytes_taken     = '0;
        size_hdr        = '0;
        dot_found       = 1'b0;
        extraction_over = 1'b0;
    endfunction

    function automatic logic [63:0] byte_capacity();
        return ({48'd0, img_w} * {48'd0, img_h} * 64'd3) / 64'd8;
    endfunction

    function automatic status_t take_hidden_byte(logic [7:0] b);
        logic [63:0] cap;
        logic [63:0] end_pos;
        status_t     st;
        cap = byte_capacity();
        if (bytes_taken < HEADER_BYTES)
            size_hdr = {size_hdr[23:0], b};
        bytes_taken = bytes_taken + 32'd1;
        end_pos = {32'd0, size_hdr} + {32'd0, HEADER_BYTES};
        if (bytes_taken == HEADER_BYTES && end_pos > cap)
            return ST_TOO_LARGE;
        st = ST_RUN;
        // payload end is only looked at once the size header is complete
        if (bytes_taken >= HEADER_BYTES && {32'd0, bytes_taken} >= end_pos)
        begin
            if (enc_mode)
                st = ST_DONE;
            else if (!dot_found && b == DOT_CHAR)
                dot_found = 1'b1;
            else if (dot_found && b == 8'h00)
                st = ST_DONE;
        end
        if (st == ST_RUN && {32'd0, bytes_taken} >= cap)
            st = ST_CAPACITY;
        return st;
    endfunction

    function automatic void absorb_pixel(logic sof, logic [23:0] pix);
        logic [2:0]  lsbs;
        logic [7:0]  b;
        logic [31:0] num;
        status_t     st;
        if (sof)
            clear_extraction();
        if (extraction_over)
            return;
        lsbs = {pix[16], pix[8], pix[0]};
        for (int k = 0; k < 3; k++)
        begin
            if (!extraction_over)
            begin
                shift_reg = {shift_reg[6:0], lsbs[k]};
                nbits++;
                if (nbits == 8)
                begin
                    b         = shift_reg;
                    num       = bytes_taken;
                    shift_reg = '0;
                    nbits     = 0;
                    st        = take_hidden_byte(b);
                    // leftover bits of the closing pixel are dropped
                    if (st != ST_RUN)
                        extraction_over = 1'b1;
                    expected_bytes.push_back('{b, num, size_hdr, st});
                end
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hidden_byte_t want;
        if (!rst_n)
        begin
            img_w    = '0;
            img_h    = '0;
            enc_mode = 1'b0;
            clear_extraction();
            expected_bytes.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:    img_w    = cfg_data;
                    CFG_IMAGE_HEIGHT:   img_h    = cfg_data;
                    CFG_ENCRYPTED_MODE: enc_mode = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                absorb_pixel(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, got byte %h number %0d",
                             $time, m_tdata[7:0], m_tdata[39:8]);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (m_tdata[7:0] !== want.data || m_tdata[39:8] !== want.number ||
                        m_tdata[71:40] !== want.size || m_tuser !== want.status ||
                        m_tlast !== (want.status != ST_RUN))
                    begin
                        fail_count++;
                        $display({"%0t: result mismatch, expected byte %h number %0d size %h",
                                  " status %0d last %0b, got byte %h number %0d size %h",
                                  " status %0d last %0b"},
                                 $time, want.data, want.number, want.size, want.status,
                                 want.status != ST_RUN, m_tdata[7:0], m_tdata[39:8],
                                 m_tdata[71:40], m_tuser, m_tlast);
                    end
                end
            end
            pending = expected_bytes.size();
        end
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import lsb1_pkg::*;

    localparam int RANDOM_PIXELS = 1100;

    typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_t;
    typedef enum int {IMG_GOOD, IMG_TRUNCATED, IMG_TOO_LARGE, IMG_NOISE} image_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    cfg_idx_t    cfg_index = CFG_IMAGE_WIDTH;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    logic        s_fire = 1'b0;
    int          fail_count;
    int          pending;

    logic [7:0]  msg_bytes[$];
    int          burst_left = 0;
    int          pixels_sent = 0;
    logic [15:0] cur_w = '0;
    logic [15:0] cur_h = '0;
    logic        cur_enc = 1'b0;

    logic [7:0]  rdy_cycle = '0;
    int          rdy_mode = 0;

    always #5 clk = ~clk;

    // transaction seen at the edge, picked up by the sender at the next falling edge
    always @(posedge clk)
        s_fire <= s_tvalid && s_tready;

    always @(negedge clk)
    begin
        rdy_cycle <= rdy_cycle + 8'd1;
        if (rdy_cycle[5:0] == 6'd0)
            rdy_mode <= $urandom_range(0, 3);
        case (rdy_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (rdy_cycle[1:0] == 2'd0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    lsb1_stego_extractor_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    lsb1_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    task automatic push_pixel(input logic sof, input logic [23:0] pix);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_tvalid = 1'b1;
        s_tuser  = sof;
        s_tdata  = pix;
        do @(negedge clk); while (!s_fire);
        burst_left--;
        pixels_sent++;
    endtask

    function automatic logic [23:0] make_pixel(logic b, logic g, logic r, fill_t fill);
        logic [23:0] p;
        case (fill)
            FILL_ZEROS: p = '0;
            FILL_ONES:  p = '1;
            default:    p = 24'($urandom());
        endcase
        p[0]  = b;
        p[8]  = g;
        p[16] = r;
        return p;
    endfunction

    // hides msg_bytes msb first, three bits per pixel
    task automatic send_message(input logic sof_first, input fill_t fill, input int extra);
        int nbits;
        int idx;
        logic [2:0] bits3;
        nbits = msg_bytes.size() * 8;
        for (int i = 0; i < nbits; i += 3)
        begin
            for (int k = 0; k < 3; k++)
            begin
                idx = i + k;
                if (idx < nbits)
                    bits3[k] = msg_bytes[idx / 8][7 - idx % 8];
                else
                    bits3[k] = 1'($urandom_range(0, 1));
            end
            push_pixel(sof_first && i == 0, make_pixel(bits3[0], bits3[1], bits3[2], fill));
        end
        repeat (extra) push_pixel(1'b0, 24'($urandom()));
    endtask

    task automatic settle();
        s_tvalid = 1'b0;
        do @(negedge clk); while (pending != 0);
        // pixels still in the pipe may close no byte
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_IMAGE_WIDTH:    cur_w   = val;
            CFG_IMAGE_HEIGHT:   cur_h   = val;
            CFG_ENCRYPTED_MODE: cur_enc = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [15:0] w, input logic [15:0] h, input logic enc);
        settle();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        // upper bits of the mode register are don't-care
        write_reg(CFG_ENCRYPTED_MODE, {15'($urandom()), enc});
    endtask

    task automatic load_header(input logic [31:0] size);
        msg_bytes.delete();
        for (int i = 3; i >= 0; i--)
            msg_bytes.push_back(size[8 * i +: 8]);
    endtask

    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 7))
            0:       return DOT_CHAR;
            1:       return 8'h00;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(1, 8));
            5, 6:    return 16'($urandom_range(1, 64));
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic build_image(input image_kind_t kind);
        logic [63:0] cap;
        logic [63:0] room;
        logic [31:0] size;
        int          top_sz;
        int          cut;
        cap  = ({48'd0, cur_w} * {48'd0, cur_h} * 64'd3) / 64'd8;
        room = (cap > 64'd4) ? cap - 64'd4 : 64'd0;
        if (kind == IMG_NOISE)
        begin
            msg_bytes.delete();
            repeat ($urandom_range(1, 6)) msg_bytes.push_back(8'($urandom()));
            return;
        end
        if (kind == IMG_TOO_LARGE)
        begin
            if ($urandom_range(0, 3) == 0)
                size = 32'hFFFF_FFFF;
            else
                size = room[31:0] + 32'd1 + 32'($urandom_range(0, 3));
            load_header(size);
            repeat ($urandom_range(0, 2)) msg_bytes.push_back(8'($urandom()));
            return;
        end
        top_sz = (room > 64'd20) ? 20 : int'(room);
        size = 32'($urandom_range(0, top_sz));
        // a payload that fills the image exactly
        if ($urandom_range(0, 3) == 0 && room <= 64'd40)
            size = room[31:0];
        load_header(size);
        repeat (size) msg_bytes.push_back(payload_byte());
        if (!cur_enc)
        begin
            repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom()));
            msg_bytes.push_back(DOT_CHAR);
            repeat ($urandom_range(0, 2)) msg_bytes.push_back(8'($urandom_range(1, 255)));
            msg_bytes.push_back(8'h00);
        end
        if (kind == IMG_TRUNCATED)
        begin
            cut = $urandom_range(0, msg_bytes.size() - 1);
            while (msg_bytes.size() > cut)
                void'(msg_bytes.pop_back());
        end
    endtask

    initial
    begin
        #(2_000_000);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        image_kind_t kind;
        int          r;
        int          random_end;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // zero capacity straight out of reset, trailing pixels dropped
        msg_bytes.delete();
        msg_bytes.push_back(8'hA5);
        send_message(1'b1, FILL_ONES, 2);

        // all-ones size header against the largest image
        configure(16'hFFFF, 16'hFFFF, 1'b1);
        load_header(32'hFFFF_FFFF);
        send_message(1'b1, FILL_ZEROS, 0);

        // payload end and capacity on the same byte (capacity 5)
        configure(16'd14, 16'd1, 1'b1);
        load_header(32'd1);
        msg_bytes.push_back(DOT_CHAR);
        send_message(1'b1, FILL_ONES, 0);

        random_end = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < random_end)
        begin
            configure(pick_dim(), pick_dim(), 1'($urandom_range(0, 1)));
            repeat (4)
            begin
                r = $urandom_range(0, 9);
                if (r < 6)
                    kind = IMG_GOOD;
                else if (r < 8)
                    kind = IMG_TRUNCATED;
                else if (r == 8)
                    kind = IMG_TOO_LARGE;
                else
                    kind = IMG_NOISE;
                build_image(kind);
                if (kind == IMG_NOISE)
                    send_message(1'($urandom_range(0, 1)), FILL_RANDOM, $urandom_range(0, 4));
                else
                    send_message(1'b1, FILL_RANDOM, $urandom_range(0, 4));
            end
        end

        s_tvalid = 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
